// ===== hdl/okv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okv_pkg: shared types and codes for the ordered key/value set
// Request and result payloads, action codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package okv_pkg;

  localparam int KEY_W = 10;
  localparam int VAL_W = 32;

  localparam logic [2:0] ACT_FIND   = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_CEIL   = 3'd3;
  localparam logic [2:0] ACT_FLOOR  = 3'd4;

  typedef struct packed {
    logic [2:0]       action;
    logic [KEY_W-1:0] req_key;
    logic [VAL_W-1:0] req_value;
  } okv_in_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] found_key;
    logic [VAL_W-1:0] found_value;
  } okv_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_ROW2,
    ST_VAL
  } okv_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic scan2;
    logic finish_miss;
    logic finish_hit;
  } okv_cmd_t;

  typedef struct packed {
    logic own_hit;
    logic nbr_hit;
  } okv_stat_t;

endpackage

// ===== hdl/ordered_key_value_set_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_value_set_core: ordered key/value map
// Find, insert, delete, ceiling and floor over a 2^KEY_BITS key universe.
// ----------------------------------------------------------------------------
// Raise start with a request while busy is low; the item is taken at that
// edge and busy stays high until the result is issued. A result appears on
// out_res for exactly one cycle with out_strobe high and must be captured
// then: there is no backpressure. A miss or an insert of a new key is issued
// after the presence row read; a hit found in the request key's own cluster
// (find, insert of a present key, delete, ceiling or floor) also waits for
// the value read, and a ceiling or floor that moves on to another cluster
// reads the neighbor row first. These reads are all registered: the presence
// row of the key's cluster, the neighbor row found from the summary word,
// then the value memory. The next item may start on the cycle the strobe is
// shown. The block is ready right after reset: empty clusters are tracked
// by the summary register, so the memories need no clearing pass.
// ----------------------------------------------------------------------------
module ordered_key_value_set_core
  import okv_pkg::*;
#(
  parameter int KEY_BITS   = 10,
  parameter int VALUE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  okv_in_t  in_req,
  output logic     out_strobe,
  output okv_out_t out_res
);

  okv_cmd_t  cmd;
  okv_stat_t stat;

  okv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  okv_datapath #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .stat    (stat),
    .out_res (out_res)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.hit |-> out_res.found_value == '0)
    else $error("miss carries a nonzero value");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result issued without an item in flight");
`endif

endmodule

// ===== hdl/okv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okv_ctrl: request sequencer
// Steps each item through row read, optional neighbor row read and value
// read, and marks the result for one cycle.
// ----------------------------------------------------------------------------
module okv_ctrl
  import okv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  okv_stat_t stat,
  output okv_cmd_t  cmd,
  output logic      busy,
  output logic      out_strobe
);

  okv_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.eval = 1'b1;
        if (stat.own_hit) begin
          state_nxt = ST_VAL;
        end else if (stat.nbr_hit) begin
          state_nxt = ST_ROW2;
        end else begin
          cmd.finish_miss = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_ROW2: begin
        cmd.scan2 = 1'b1;
        state_nxt = ST_VAL;
      end
      ST_VAL: begin
        cmd.finish_hit = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.finish_miss | cmd.finish_hit;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_valid_r;

endmodule

// ===== hdl/okv_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okv_datapath: presence rows, cluster summary and value store
// Holds the two-level presence bitmap and the values, and does the
// priority-encoder searches for ceiling and floor.
// ----------------------------------------------------------------------------
module okv_datapath
  import okv_pkg::*;
#(
  parameter int KEY_BITS   = 10,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  okv_cmd_t  cmd,
  input  okv_in_t   in_req,
  output okv_stat_t stat,
  output okv_out_t  out_res
);

  localparam int LOW_BITS  = KEY_BITS / 2;
  localparam int HIGH_BITS = KEY_BITS - LOW_BITS;
  localparam int CL_SIZE   = 1 << LOW_BITS;
  localparam int NCL       = 1 << HIGH_BITS;
  localparam int NKEYS     = 1 << KEY_BITS;

  // lowest / highest set bit; the vector is never narrower than a row
  function automatic logic [HIGH_BITS-1:0] low_set(input logic [NCL-1:0] v);
    logic [HIGH_BITS-1:0] idx;
    idx = '0;
    for (int i = NCL - 1; i >= 0; i--) begin
      if (v[i]) idx = HIGH_BITS'(i);
    end
    return idx;
  endfunction

  function automatic logic [HIGH_BITS-1:0] high_set(input logic [NCL-1:0] v);
    logic [HIGH_BITS-1:0] idx;
    idx = '0;
    for (int i = 0; i < NCL; i++) begin
      if (v[i]) idx = HIGH_BITS'(i);
    end
    return idx;
  endfunction

  logic [CL_SIZE-1:0]    rows [NCL];
  logic [VALUE_BITS-1:0] vals [NKEYS];

  logic [CL_SIZE-1:0]    row_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [NCL-1:0]        sum_r;

  logic [2:0]            op_r;
  logic [KEY_W-1:0]      req_key_r;
  logic [KEY_BITS-1:0]   key_r;
  logic                  key_ok_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [KEY_BITS-1:0]   found_r;
  logic [HIGH_BITS-1:0]  nbr_r;
  okv_out_t              out_r;

  // request field conversion
  logic [KEY_BITS+KEY_W-1:0]   in_key_ext;
  logic [VALUE_BITS+VAL_W-1:0] in_val_ext;
  logic [KEY_BITS-1:0]         in_key;

  assign in_key_ext = {{KEY_BITS{1'b0}}, in_req.req_key};
  assign in_val_ext = {{VALUE_BITS{1'b0}}, in_req.req_value};
  assign in_key     = in_key_ext[KEY_BITS-1:0];

  // row evaluation
  logic [HIGH_BITS-1:0] hi;
  logic [LOW_BITS-1:0]  lo;
  logic [CL_SIZE-1:0]   row_live, up_mask, dn_mask, own_up, own_dn, bit_lo, row_new;
  logic [NCL-1:0]       c_up, c_dn;
  logic                 present, valid_op, is_ceil, is_floor, own_hit, nbr_hit;
  logic                 ins_w, del_w;
  logic [KEY_BITS-1:0]  own_key, second_key;
  logic [HIGH_BITS-1:0] nbr;
  logic [HIGH_BITS-1:0] up_idx, dn_idx, r2_idx;

  assign hi       = key_r[KEY_BITS-1:LOW_BITS];
  assign lo       = key_r[LOW_BITS-1:0];
  // a cluster without its summary bit is empty, whatever its row holds
  assign row_live = sum_r[hi] ? row_q : '0;
  assign present  = row_live[lo];
  assign bit_lo   = CL_SIZE'(1) << lo;
  assign is_ceil  = (op_r == ACT_CEIL);
  assign is_floor = (op_r == ACT_FLOOR);
  assign valid_op = key_ok_r && (op_r == ACT_FIND || op_r == ACT_INSERT ||
                    op_r == ACT_DELETE || is_ceil || is_floor);

  always_comb begin
    for (int i = 0; i < CL_SIZE; i++) begin
      up_mask[i] = (i >= int'(lo));
      dn_mask[i] = (i <= int'(lo));
    end
    for (int j = 0; j < NCL; j++) begin
      c_up[j] = sum_r[j] && (j > int'(hi));
      c_dn[j] = sum_r[j] && (j < int'(hi));
    end
  end

  assign own_up = row_live & up_mask;
  assign own_dn = row_live & dn_mask;
  assign up_idx = low_set(NCL'(own_up));
  assign dn_idx = high_set(NCL'(own_dn));

  always_comb begin
    own_key = key_r;
    own_hit = 1'b0;
    if (valid_op) begin
      if (is_ceil) begin
        own_hit = |own_up;
        own_key = {hi, up_idx[LOW_BITS-1:0]};
      end else if (is_floor) begin
        own_hit = |own_dn;
        own_key = {hi, dn_idx[LOW_BITS-1:0]};
      end else begin
        own_hit = present;
      end
    end
  end

  assign nbr     = is_ceil ? low_set(c_up) : high_set(c_dn);
  assign nbr_hit = valid_op && !own_hit && ((is_ceil && |c_up) || (is_floor && |c_dn));
  assign ins_w   = valid_op && (op_r == ACT_INSERT) && !present;
  assign del_w   = valid_op && (op_r == ACT_DELETE) && present;
  assign row_new = ins_w ? (row_live | bit_lo) : (row_live & ~bit_lo);

  assign stat.own_hit = own_hit;
  assign stat.nbr_hit = nbr_hit;

  // second row: nonempty, since its summary bit is set
  assign r2_idx     = is_ceil ? low_set(NCL'(row_q)) : high_set(NCL'(row_q));
  assign second_key = {nbr_r, r2_idx[LOW_BITS-1:0]};

  // memories
  logic [HIGH_BITS-1:0] row_ra;
  logic [KEY_BITS-1:0]  val_ra;

  assign row_ra = cmd.load ? in_key[KEY_BITS-1:LOW_BITS] : nbr;
  assign val_ra = cmd.scan2 ? second_key : own_key;

  always_ff @(posedge clk) begin
    if (cmd.eval && (ins_w || del_w)) rows[hi] <= row_new;
    row_q <= rows[row_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && ins_w) vals[key_r] <= value_r;
    val_q <= vals[val_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.eval) begin
      if (ins_w) begin
        sum_r[hi] <= 1'b1;
      end else if (del_w && (row_new == '0)) begin
        sum_r[hi] <= 1'b0;
      end
    end
  end

  // request and result payload
  logic [VALUE_BITS+VAL_W-1:0] out_val_ext;
  logic [KEY_BITS+KEY_W-1:0]   out_key_ext;

  assign out_val_ext = {{VAL_W{1'b0}}, val_q};
  assign out_key_ext = {{KEY_W{1'b0}}, found_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_req.action;
      req_key_r <= in_req.req_key;
      key_r     <= in_key;
      key_ok_r  <= (in_key_ext[KEY_BITS+KEY_W-1:KEY_BITS] == '0);
      value_r   <= in_val_ext[VALUE_BITS-1:0];
    end
    if (cmd.eval) begin
      found_r <= own_key;
      nbr_r   <= nbr;
    end else if (cmd.scan2) begin
      found_r <= second_key;
    end
    if (cmd.finish_miss) begin
      out_r.hit         <= 1'b0;
      out_r.found_key   <= req_key_r;
      out_r.found_value <= '0;
    end else if (cmd.finish_hit) begin
      out_r.hit         <= 1'b1;
      out_r.found_key   <= out_key_ext[KEY_W-1:0];
      out_r.found_value <= out_val_ext[VAL_W-1:0];
    end
  end

  assign out_res = out_r;

endmodule

// ===== tb/sv/okv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okv_checker: result checker for the ordered key/value set
// Keeps its own copy of the presence rows, the cluster summary and the value
// store, works out the answer to every request taken by the core and compares
// each strobed result with the oldest answer still waiting.
// ----------------------------------------------------------------------------
module okv_checker
  import okv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  okv_in_t  in_req,
  input  logic     out_strobe,
  input  okv_out_t out_res,
  output int       fail_count,
  output int       pending,
  output int       req_count,
  output int       hit_count
);

  localparam int LOW_W  = KEY_W / 2;
  localparam int HIGH_W = KEY_W - LOW_W;
  localparam int N_CL   = 1 << HIGH_W;
  localparam int CL_SZ  = 1 << LOW_W;
  localparam int N_KEYS = 1 << KEY_W;

  logic [CL_SZ-1:0] rows [N_CL];
  logic [N_CL-1:0]  occupied;
  logic [VAL_W-1:0] vals [N_KEYS];
  okv_out_t         expected_answers [$];
  okv_out_t         want;
  int               result_idx;

  function automatic okv_out_t answer_request(input okv_in_t req);
    logic [HIGH_W-1:0] cl;
    logic [LOW_W-1:0]  off;
    logic              present;
    logic              hit;
    logic              done;
    logic [KEY_W-1:0]  found;
    logic [VAL_W-1:0]  fval;
    okv_out_t          ans;
    int                o;
    int                c;
    cl      = req.req_key[KEY_W-1:LOW_W];
    off     = req.req_key[LOW_W-1:0];
    present = rows[cl][off];
    hit     = 1'b0;
    done    = 1'b0;
    found   = req.req_key;
    fval    = '0;
    case (req.action)
      ACT_FIND: begin
        hit = present;
      end
      ACT_INSERT: begin
        // a present key keeps its old value
        hit = present;
        if (!present) begin
          rows[cl][off]       = 1'b1;
          occupied[cl]        = 1'b1;
          vals[req.req_key]   = req.req_value;
        end
      end
      ACT_DELETE: begin
        hit = present;
        if (present) begin
          fval          = vals[req.req_key];
          rows[cl][off] = 1'b0;
          if (rows[cl] == '0) occupied[cl] = 1'b0;
        end
      end
      ACT_CEIL: begin
        if (occupied[cl])
          for (o = int'(off); o < CL_SZ; o++)
            if (!hit && rows[cl][o]) begin
              hit   = 1'b1;
              found = {cl, o[LOW_W-1:0]};
            end
        // take the lowest key of the first occupied cluster above
        for (c = int'(cl) + 1; c < N_CL; c++)
          if (!hit && !done && occupied[c]) begin
            done = 1'b1;
            for (o = 0; o < CL_SZ; o++)
              if (!hit && rows[c][o]) begin
                hit   = 1'b1;
                found = {c[HIGH_W-1:0], o[LOW_W-1:0]};
              end
          end
      end
      ACT_FLOOR: begin
        if (occupied[cl])
          for (o = int'(off); o >= 0; o--)
            if (!hit && rows[cl][o]) begin
              hit   = 1'b1;
              found = {cl, o[LOW_W-1:0]};
            end
        for (c = int'(cl) - 1; c >= 0; c--)
          if (!hit && !done && occupied[c]) begin
            done = 1'b1;
            for (o = CL_SZ - 1; o >= 0; o--)
              if (!hit && rows[c][o]) begin
                hit   = 1'b1;
                found = {c[HIGH_W-1:0], o[LOW_W-1:0]};
              end
          end
      end
      default: ;
    endcase
    if (!hit) found = req.req_key;
    else if (req.action != ACT_DELETE) fval = vals[found];
    ans.hit         = hit;
    ans.found_key   = found;
    ans.found_value = hit ? fval : '0;
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t ns: result %0d: %s got %0h, want %0h",
             $time, result_idx, what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_CL; i++) rows[i] = '0;
      occupied   = '0;
      expected_answers.delete();
      pending    = 0;
      result_idx = 0;
      fail_count = 0;
      req_count  = 0;
      hit_count  = 0;
    end else begin
      if (out_strobe) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result with no request waiting, key", 64'(out_res.found_key), '0);
        end else begin
          want = expected_answers.pop_front();
          if (out_res.hit !== want.hit)
            report_mismatch("hit", 64'(out_res.hit), 64'(want.hit));
          if (out_res.found_key !== want.found_key)
            report_mismatch("found_key", 64'(out_res.found_key), 64'(want.found_key));
          if (out_res.found_value !== want.found_value)
            report_mismatch("found_value", 64'(out_res.found_value),
                            64'(want.found_value));
          if (want.hit) hit_count++;
        end
        result_idx++;
      end
      if (start && !busy) begin
        expected_answers.push_back(answer_request(in_req));
        req_count++;
      end
      pending = expected_answers.size();
    end
  end

endmodule

// ===== tb/sv/ordered_key_value_set_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_value_set_core_tb: testbench top for the ordered key/value set
// Drives a directed set of boundary requests, then random requests in
// alternating fill and drain phases, issued in bursts with random gaps.
// The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module ordered_key_value_set_core_tb;
  import okv_pkg::*;

  // highest code the action field can carry
  localparam logic [2:0] ACT_TOP = 3'd7;
  localparam int RANDOM_ITEMS = 1550;
  localparam int PHASE_LEN    = 200;

  logic     clk    = 1'b0;
  logic     rst_n  = 1'b0;
  logic     start  = 1'b0;
  okv_in_t  in_req = '0;
  logic     busy;
  logic     out_strobe;
  okv_out_t out_res;

  int fail_count;
  int pending;
  int req_count;
  int hit_count;

  int               burst_left;
  int               recent_keys [$];
  logic [KEY_W-1:0] window_base;
  bit               filling;

  always #5 clk = ~clk;

  ordered_key_value_set_core #(
    .KEY_BITS   (KEY_W),
    .VALUE_BITS (VAL_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  okv_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .fail_count (fail_count),
    .pending    (pending),
    .req_count  (req_count),
    .hit_count  (hit_count)
  );

  function automatic okv_in_t make_req(input logic [2:0] act, input logic [KEY_W-1:0] key,
                                       input logic [VAL_W-1:0] value);
    okv_in_t r;
    r.action    = act;
    r.req_key   = key;
    r.req_value = value;
    return r;
  endfunction

  // Hold the item until the core takes it, then keep going or pause.
  task automatic issue_request(input okv_in_t req);
    int gap;
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req.action == ACT_INSERT) begin
      recent_keys.push_back(int'(req.req_key));
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(0, 23);
      if (gap != 0) begin
        start  <= 1'b0;
        in_req <= make_req(3'($urandom), KEY_W'($urandom), $urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return window_base + KEY_W'($urandom_range(0, 95));
    if (r < 75 && recent_keys.size() > 0)
      return KEY_W'(recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
    return KEY_W'($urandom);
  endfunction

  function automatic logic [2:0] pick_action();
    int r;
    int ins_w;
    r     = $urandom_range(0, 99);
    ins_w = filling ? 40 : 10;
    if (r < ins_w) return ACT_INSERT;
    if (r < 50)    return ACT_DELETE;
    if (r < 65)    return ACT_FIND;
    if (r < 80)    return ACT_CEIL;
    if (r < 95)    return ACT_FLOOR;
    return 3'($urandom_range(int'(ACT_FLOOR) + 1, int'(ACT_TOP)));
  endfunction

  initial begin
    int drain_cycles;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty map: every lookup misses
    issue_request(make_req(ACT_FIND,   10'd0,    32'h0000_0001));
    issue_request(make_req(ACT_CEIL,   10'd0,    32'h0));
    issue_request(make_req(ACT_FLOOR,  10'd1023, 32'h0));
    issue_request(make_req(ACT_DELETE, 10'd5,    32'h0));
    // both ends of the key range, extreme values, insert of a present key
    issue_request(make_req(ACT_INSERT, 10'd0,    32'h0000_0000));
    issue_request(make_req(ACT_INSERT, 10'd1023, 32'hFFFF_FFFF));
    issue_request(make_req(ACT_INSERT, 10'd1023, 32'h1234_5678));
    issue_request(make_req(ACT_FIND,   10'd1023, 32'h0));
    issue_request(make_req(ACT_FIND,   10'd0,    32'h0));
    issue_request(make_req(ACT_FIND,   10'd512,  32'h0));
    // searches that cross to the far cluster, then hits on both end keys
    issue_request(make_req(ACT_CEIL,   10'd1,    32'h0));
    issue_request(make_req(ACT_FLOOR,  10'd1022, 32'h0));
    issue_request(make_req(ACT_CEIL,   10'd1023, 32'h0));
    issue_request(make_req(ACT_FLOOR,  10'd0,    32'h0));
    // searches inside one cluster, and a floor that falls back to a lower one
    issue_request(make_req(ACT_INSERT, 10'd37,   32'hA5A5_A5A5));
    issue_request(make_req(ACT_INSERT, 10'd40,   32'h5A5A_5A5A));
    issue_request(make_req(ACT_CEIL,   10'd38,   32'h0));
    issue_request(make_req(ACT_FLOOR,  10'd39,   32'h0));
    issue_request(make_req(ACT_FLOOR,  10'd36,   32'h0));
    // delete present, then absent
    issue_request(make_req(ACT_DELETE, 10'd37,   32'h0));
    issue_request(make_req(ACT_DELETE, 10'd37,   32'h0));
    issue_request(make_req(ACT_CEIL,   10'd33,   32'h0));
    // undefined action codes change nothing
    issue_request(make_req(ACT_FLOOR + 3'd1, 10'd40, 32'hDEAD_BEEF));
    issue_request(make_req(ACT_FLOOR + 3'd2, 10'd40, 32'h0));
    issue_request(make_req(ACT_TOP,          10'd40, 32'hFFFF_FFFF));
    // empty the map again and search it
    issue_request(make_req(ACT_DELETE, 10'd40,   32'h0));
    issue_request(make_req(ACT_DELETE, 10'd0,    32'h0));
    issue_request(make_req(ACT_DELETE, 10'd1023, 32'h0));
    issue_request(make_req(ACT_CEIL,   10'd0,    32'h0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_LEN == 0) begin
        filling     = ((i / PHASE_LEN) % 2) == 0;
        window_base = KEY_W'($urandom);
      end
      issue_request(make_req(pick_action(), pick_key(), $urandom));
    end
    start <= 1'b0;

    drain_cycles = 0;
    while (pending != 0 && drain_cycles < 200) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);

    $display("covered %0d requests with %0d hits, fill and drain phases, bursty issue",
             req_count, hit_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ordered_key_value_set_core: match");
    end else begin
      $display("ordered_key_value_set_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ordered_key_value_set_core: mismatch");
    $finish;
  end

endmodule
